// ===== rtl/core/bcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and arithmetic constants for the balance controller.
package bcc_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIDDLE_ANGLE   = 3'd0,
        REG_BALANCE_KP     = 3'd1,
        REG_BALANCE_KD     = 3'd2,
        REG_VELOCITY_KP    = 3'd3,
        REG_VELOCITY_KI    = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_TILT_LIMIT     = 3'd6,
        REG_PWM_LIMIT      = 3'd7
    } cfg_index_t;

    // Register reset values
    localparam logic signed [12:0] MIDDLE_ANGLE_RST   = 13'sd0;
    localparam logic [15:0]        BALANCE_KP_RST     = 16'd57600;
    localparam logic [15:0]        BALANCE_KD_RST     = 16'd276;
    localparam logic [15:0]        VELOCITY_KP_RST    = 16'd40960;
    localparam logic [15:0]        VELOCITY_KI_RST    = 16'd205;
    localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd10000;
    localparam logic [13:0]        TILT_LIMIT_RST     = 14'd4000;
    localparam logic [12:0]        PWM_LIMIT_RST      = 13'd6900;

    // Serial arithmetic sizing
    localparam int GAIN_W    = 16;              // multiplier bits, one per step
    localparam int MAG_W     = 25;              // widest multiplicand magnitude
    localparam int LANE_W    = GAIN_W + MAG_W;  // product register
    localparam int DIVN_W    = 27;              // divider numerator, one bit per step
    localparam int FILT_W    = 26;              // filtered error and integral, Q.8
    localparam int SUM_W     = 28;              // final signed sums
    localparam int MUL_STEPS = GAIN_W;
    localparam int DIV_STEPS = DIVN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int DIV5_K      = 5;
    localparam int DIV100_K    = 100;
    localparam int REM5_W      = $clog2(DIV5_K);
    localparam int REM100_W    = $clog2(DIV100_K);

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] tilt_rate;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic               key_click;
    } in_item_t;

    typedef struct packed {
        logic signed [13:0] motor_command;
        logic [12:0]        duty;
        logic               left_in1;
        logic               left_in2;
        logic               right_in1;
        logic               right_in2;
        logic               shut_off;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_DIV,
        ST_FUPD,
        ST_IUPD,
        ST_MUL2,
        ST_SUM,
        ST_OUT
    } bcc_state_t;

endpackage

// ===== rtl/core/balance_cascade_controller.sv =====
`timescale 1ns / 1ps
// Two-wheel balance controller: PD tilt loop plus PI wheel-speed loop, bit-serial datapath.
// Every second accepted tick computes; the other ticks only flip the phase. A computing
// tick keeps in_ready low from acceptance until its result is loaded: a setup state, a
// 16-step shift-add pass that forms the two balance products, a 27-step restoring divide
// that runs the /5 speed filter and the /100 angle scaling side by side, a filter update
// and an integral update state, a second 16-step multiply pass for the speed terms, a sum
// state, and an output state that clamps and loads the result register. No new tick is
// taken while one computes. The result register lets the next item in while a result
// waits on out_ready. Configuration registers are written with cfg_we and may change
// only while the block is idle.
module balance_cascade_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bcc_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bcc_pkg::out_item_t                  out_item
);
    import bcc_pkg::*;

    // Configuration
    logic signed [12:0] middle_angle_reg;
    logic [15:0]        balance_kp_reg;
    logic [15:0]        balance_kd_reg;
    logic [15:0]        velocity_kp_reg;
    logic [15:0]        velocity_ki_reg;
    logic [15:0]        integral_limit_reg;
    logic [13:0]        tilt_limit_reg;
    logic [12:0]        pwm_limit_reg;

    // Control and loop state
    bcc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                skip_phase_reg;
    logic                stopped_reg;
    logic [FILT_W-1:0]   filt_reg;
    logic [FILT_W-1:0]   integ_reg;
    logic [12:0]         held_duty_reg;
    logic                out_valid_reg;

    // Datapath
    in_item_t            item_reg;
    logic [LANE_W-1:0]   lane_a_reg, lane_b_reg;
    logic [MAG_W-1:0]    mcand_a_reg, mcand_b_reg;
    logic [DIVN_W-1:0]   div5_reg, div100_reg;
    logic [REM5_W-1:0]   rem5_reg;
    logic [REM100_W-1:0] rem100_reg;
    logic [23:0]         dq_reg;
    logic                diff_neg_reg, rate_neg_reg, s_neg_reg, i_neg_reg, off_reg;
    logic [DIVN_W-1:0]   isum_reg;
    logic [SUM_W-1:0]    bal_reg, vel_reg;
    out_item_t           out_item_reg;

    logic in_take, out_free, out_load, mul_last, div_last;

    // ---------------------------------------------------------------- control
    assign mul_last = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && skip_phase_reg)
                    state_next = ST_PREP;
            end
            ST_PREP: state_next = ST_MUL1;
            ST_MUL1:
            begin
                if (mul_last)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_FUPD;
            end
            ST_FUPD: state_next = ST_IUPD;
            ST_IUPD: state_next = ST_MUL2;
            ST_MUL2:
            begin
                if (mul_last)
                    state_next = ST_SUM;
            end
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        in_take  = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;
        out_load = (state_reg == ST_OUT) && out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------------------------------------------------------- arithmetic
    // Setup: magnitudes and signs of the balance inputs and the filter numerator
    logic signed [16:0] prep_diff, prep_angle, prep_tilt;
    logic [16:0]        prep_diff_abs;
    logic [15:0]        prep_rate_abs;
    logic signed [16:0] prep_wheel;
    logic signed [27:0] prep_speed;
    logic [27:0]        prep_speed_abs;
    logic               prep_off;

    always_comb
    begin
        prep_diff = $signed({{4{middle_angle_reg[12]}}, middle_angle_reg})
                  - $signed({item_reg.tilt_angle[15], item_reg.tilt_angle});
        prep_diff_abs = prep_diff[16] ? 17'(-prep_diff) : prep_diff;
        prep_rate_abs = item_reg.tilt_rate[15] ? 16'(-item_reg.tilt_rate)
                                               : item_reg.tilt_rate;
        prep_wheel = $signed({item_reg.left_count[15], item_reg.left_count})
                   + $signed({item_reg.right_count[15], item_reg.right_count});
        // 4*F + 256*e with e the negated wheel sum
        prep_speed = $signed({filt_reg, 2'b00})
                   - $signed({{3{prep_wheel[16]}}, prep_wheel, 8'd0});
        prep_speed_abs = prep_speed[27] ? 28'(-prep_speed) : prep_speed;
        prep_angle = $signed({item_reg.tilt_angle[15], item_reg.tilt_angle});
        prep_tilt  = $signed({3'b000, tilt_limit_reg});
        prep_off   = (prep_angle > prep_tilt) || (prep_angle < -prep_tilt) || stopped_reg;
    end

    // Shift-add lanes: add multiplicand into the upper half, shift right one bit
    logic [MAG_W:0]    a_add, b_add;
    logic [LANE_W-1:0] a_step, b_step;

    always_comb
    begin
        a_add  = {1'b0, lane_a_reg[LANE_W-1:GAIN_W]}
               + (lane_a_reg[0] ? {1'b0, mcand_a_reg} : (MAG_W + 1)'(0));
        b_add  = {1'b0, lane_b_reg[LANE_W-1:GAIN_W]}
               + (lane_b_reg[0] ? {1'b0, mcand_b_reg} : (MAG_W + 1)'(0));
        a_step = {a_add, lane_a_reg[GAIN_W-1:1]};
        b_step = {b_add, lane_b_reg[GAIN_W-1:1]};
    end

    // Restoring divide steps, one quotient bit per cycle
    logic [REM5_W:0]   d5_trial;
    logic [REM100_W:0] d100_trial;
    logic              d5_ge, d100_ge;
    logic [REM5_W-1:0]   d5_rem;
    logic [REM100_W-1:0] d100_rem;

    always_comb
    begin
        d5_trial   = {rem5_reg, div5_reg[DIVN_W-1]};
        d5_ge      = d5_trial >= (REM5_W + 1)'(DIV5_K);
        d5_rem     = d5_ge ? REM5_W'(d5_trial - (REM5_W + 1)'(DIV5_K)) : d5_trial[REM5_W-1:0];
        d100_trial = {rem100_reg, div100_reg[DIVN_W-1]};
        d100_ge    = d100_trial >= (REM100_W + 1)'(DIV100_K);
        d100_rem   = d100_ge ? REM100_W'(d100_trial - (REM100_W + 1)'(DIV100_K))
                             : d100_trial[REM100_W-1:0];
    end

    // Filter result and integral sum
    logic [FILT_W-1:0] fupd_q, fupd_f;
    logic [DIVN_W-1:0] fupd_isum;

    always_comb
    begin
        fupd_q    = div5_reg[FILT_W-1:0];
        fupd_f    = s_neg_reg ? (~fupd_q + FILT_W'(1)) : fupd_q;
        fupd_isum = {integ_reg[FILT_W-1], integ_reg} + {fupd_f[FILT_W-1], fupd_f};
    end

    // Integral clamp
    logic [DIVN_W-1:0] ilim, ilim_neg, iupd_clamp, iupd_abs;
    logic              iupd_over, iupd_under;
    logic [MAG_W-1:0]  iupd_mag;

    always_comb
    begin
        ilim       = {3'b000, integral_limit_reg, 8'd0};
        ilim_neg   = ~ilim + DIVN_W'(1);
        iupd_over  = $signed(isum_reg) > $signed(ilim);
        iupd_under = $signed(isum_reg) < $signed(ilim_neg);
        iupd_abs   = isum_reg[DIVN_W-1] ? (~isum_reg + DIVN_W'(1)) : isum_reg;
        if (iupd_over)
            iupd_clamp = ilim;
        else if (iupd_under)
            iupd_clamp = ilim_neg;
        else
            iupd_clamp = isum_reg;
        iupd_mag = (iupd_over || iupd_under) ? ilim[MAG_W-1:0] : iupd_abs[MAG_W-1:0];
    end

    // Term sums
    logic [SUM_W-1:0] pqx, dqx, fqx, iqx, sum_bal, sum_vel;

    always_comb
    begin
        pqx     = {1'b0, div100_reg};
        dqx     = SUM_W'(dq_reg);
        fqx     = SUM_W'(lane_a_reg[LANE_W-1:GAIN_W]);
        iqx     = SUM_W'(lane_b_reg[LANE_W-1:GAIN_W]);
        sum_bal = (diff_neg_reg ? pqx : -pqx) + (rate_neg_reg ? -dqx : dqx);
        sum_vel = (s_neg_reg ? fqx : -fqx) + (i_neg_reg ? iqx : -iqx);
    end

    // Command clamp and bridge bits
    logic [SUM_W-1:0] cmd_total, cmd_lim, cmd_lim_neg, cmd_full;
    logic [13:0]      cmd, cmd_abs;
    logic             cmd_pos;
    out_item_t        out_new;

    always_comb
    begin
        cmd_total   = bal_reg + vel_reg;
        cmd_lim     = SUM_W'(pwm_limit_reg);
        cmd_lim_neg = -cmd_lim;
        if ($signed(cmd_total) > $signed(cmd_lim))
            cmd_full = cmd_lim;
        else if ($signed(cmd_total) < $signed(cmd_lim_neg))
            cmd_full = cmd_lim_neg;
        else
            cmd_full = cmd_total;
        cmd     = cmd_full[13:0];
        cmd_pos = !cmd[13] && (cmd != 14'd0);
        cmd_abs = cmd[13] ? (~cmd + 14'd1) : cmd;

        out_new.motor_command = $signed(cmd);
        if (off_reg)
        begin
            out_new.duty      = held_duty_reg;
            out_new.left_in1  = 1'b0;
            out_new.left_in2  = 1'b0;
            out_new.right_in1 = 1'b0;
            out_new.right_in2 = 1'b0;
            out_new.shut_off  = 1'b1;
        end
        else
        begin
            out_new.duty      = cmd_abs[12:0];
            out_new.left_in1  = cmd_pos;
            out_new.left_in2  = !cmd_pos;
            out_new.right_in1 = !cmd_pos;
            out_new.right_in2 = cmd_pos;
            out_new.shut_off  = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            middle_angle_reg   <= MIDDLE_ANGLE_RST;
            balance_kp_reg     <= BALANCE_KP_RST;
            balance_kd_reg     <= BALANCE_KD_RST;
            velocity_kp_reg    <= VELOCITY_KP_RST;
            velocity_ki_reg    <= VELOCITY_KI_RST;
            integral_limit_reg <= INTEGRAL_LIMIT_RST;
            tilt_limit_reg     <= TILT_LIMIT_RST;
            pwm_limit_reg      <= PWM_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIDDLE_ANGLE:   middle_angle_reg   <= $signed(cfg_data[12:0]);
                REG_BALANCE_KP:     balance_kp_reg     <= cfg_data;
                REG_BALANCE_KD:     balance_kd_reg     <= cfg_data;
                REG_VELOCITY_KP:    velocity_kp_reg    <= cfg_data;
                REG_VELOCITY_KI:    velocity_ki_reg    <= cfg_data;
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data;
                REG_TILT_LIMIT:     tilt_limit_reg     <= cfg_data[13:0];
                REG_PWM_LIMIT:      pwm_limit_reg      <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            skip_phase_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            filt_reg       <= '0;
            integ_reg      <= '0;
            held_duty_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == ST_MUL1) || (state_reg == ST_MUL2))
                cnt_reg <= mul_last ? '0 : cnt_reg + CNT_W'(1);
            else if (state_reg == ST_DIV)
                cnt_reg <= div_last ? '0 : cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;

            // Flip phase on every item; a click counts only on a computing tick
            if (in_take)
            begin
                skip_phase_reg <= !skip_phase_reg;
                if (skip_phase_reg && in_item.key_click)
                    stopped_reg <= !stopped_reg;
            end

            if (state_reg == ST_FUPD)
                filt_reg <= fupd_f;

            if (state_reg == ST_IUPD)
                integ_reg <= off_reg ? '0 : iupd_clamp[FILT_W-1:0];

            if (out_load && !off_reg)
                held_duty_reg <= cmd_abs[12:0];

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_item;

        if (out_load)
            out_item_reg <= out_new;

        unique case (state_reg)
            ST_PREP:
            begin
                lane_a_reg   <= LANE_W'(balance_kp_reg);
                mcand_a_reg  <= MAG_W'(prep_diff_abs[15:0]);
                lane_b_reg   <= LANE_W'(balance_kd_reg);
                mcand_b_reg  <= MAG_W'(prep_rate_abs);
                diff_neg_reg <= prep_diff[16];
                rate_neg_reg <= item_reg.tilt_rate[15];
                s_neg_reg    <= prep_speed[27];
                div5_reg     <= prep_speed_abs[DIVN_W-1:0];
                rem5_reg     <= '0;
                off_reg      <= prep_off;
            end
            ST_MUL1:
            begin
                lane_a_reg <= a_step;
                lane_b_reg <= b_step;
                // Drop eight fraction bits; the angle product then goes on to /100
                if (mul_last)
                begin
                    div100_reg <= DIVN_W'(a_step[31:8]);
                    rem100_reg <= '0;
                    dq_reg     <= b_step[31:8];
                end
            end
            ST_DIV:
            begin
                div5_reg   <= {div5_reg[DIVN_W-2:0], d5_ge};
                rem5_reg   <= d5_rem;
                div100_reg <= {div100_reg[DIVN_W-2:0], d100_ge};
                rem100_reg <= d100_rem;
            end
            ST_FUPD:
            begin
                isum_reg    <= fupd_isum;
                lane_a_reg  <= LANE_W'(velocity_kp_reg);
                mcand_a_reg <= div5_reg[MAG_W-1:0];
            end
            ST_IUPD:
            begin
                i_neg_reg   <= iupd_clamp[DIVN_W-1];
                lane_b_reg  <= LANE_W'(velocity_ki_reg);
                mcand_b_reg <= iupd_mag;
            end
            ST_MUL2:
            begin
                lane_a_reg <= a_step;
                lane_b_reg <= b_step;
            end
            ST_SUM:
            begin
                bal_reg <= sum_bal;
                vel_reg <= sum_vel;
            end
            default: ;
        endcase
    end

endmodule
